[rtl/gcc_pkg.sv]
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types, codes and helpers for the two-player game clock.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int TimeW  = 32;
    localparam int MovesW = 16;
    localparam int CfgIdxW = 3;

    typedef logic [TimeW-1:0]  t_time;
    typedef logic [MovesW-1:0] t_moves;
    typedef logic [1:0]        t_side;
    typedef logic [1:0]        t_cmd;
    typedef logic [2:0]        t_mode;

    // Commands
    localparam t_cmd CMD_TICK  = 2'd0;
    localparam t_cmd CMD_PRESS = 2'd1;
    localparam t_cmd CMD_LOAD  = 2'd2;

    // Player codes
    localparam t_side SIDE_NONE  = 2'd0;
    localparam t_side SIDE_LEFT  = 2'd1;
    localparam t_side SIDE_RIGHT = 2'd2;

    // Time-control modes
    localparam t_mode MODE_SUDDEN       = 3'd0;
    localparam t_mode MODE_PER_MOVE_ADD = 3'd1;
    localparam t_mode MODE_GRACE        = 3'd2;
    localparam t_mode MODE_TRANSFER     = 3'd3;
    localparam t_mode MODE_CAPPED_ADD   = 3'd4;
    localparam t_mode MODE_STAGED       = 3'd5;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_CLOCK_MODE     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_BONUS          = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FIRST_CAP      = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SECOND_CAP     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MID_INC        = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LATE_INC       = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_FIRST_CAP_BON  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SECOND_CAP_BON = 3'd7;

    localparam t_moves MOVES_MAX = '1;

    typedef struct packed {
        t_mode  clock_mode;
        t_time  bonus_ms;
        t_moves first_cap_moves;
        t_moves second_cap_moves;
        t_time  mid_increment_ms;
        t_time  late_increment_ms;
        t_time  first_cap_bonus_ms;
        t_time  second_cap_bonus_ms;
    } t_cfg;

    typedef struct packed {
        t_time  left_remaining;
        t_time  right_remaining;
        t_moves left_moves;
        t_moves right_moves;
        t_side  active_side;
        t_time  grace_left;
        t_side  outcome;
    } t_state;

    // Add two times, saturating at the all-ones value
    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TimeW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TimeW] ? '1 : sum[TimeW-1:0];
    endfunction

endpackage

[rtl/gcc_cfg.sv]
// ----------------------------------------------------------------------------
// gcc_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module gcc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gcc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output gcc_pkg::t_cfg               o_cfg
);

    gcc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write one register per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gcc_pkg::REG_CLOCK_MODE:     r_cfg.clock_mode          <= i_cfg_data[2:0];
                gcc_pkg::REG_BONUS:          r_cfg.bonus_ms            <= i_cfg_data;
                gcc_pkg::REG_FIRST_CAP:      r_cfg.first_cap_moves     <= i_cfg_data[15:0];
                gcc_pkg::REG_SECOND_CAP:     r_cfg.second_cap_moves    <= i_cfg_data[15:0];
                gcc_pkg::REG_MID_INC:        r_cfg.mid_increment_ms    <= i_cfg_data;
                gcc_pkg::REG_LATE_INC:       r_cfg.late_increment_ms   <= i_cfg_data;
                gcc_pkg::REG_FIRST_CAP_BON:  r_cfg.first_cap_bonus_ms  <= i_cfg_data;
                gcc_pkg::REG_SECOND_CAP_BON: r_cfg.second_cap_bonus_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[rtl/gcc_core.sv]
// ----------------------------------------------------------------------------
// gcc_core
// Next-state logic: applies one tick, press or load to the clock state.
// ----------------------------------------------------------------------------
module gcc_core (
    input  gcc_pkg::t_cfg   i_cfg,
    input  gcc_pkg::t_state i_state,
    input  gcc_pkg::t_cmd   i_cmd,
    input  gcc_pkg::t_time  i_amount_ms,
    input  gcc_pkg::t_side  i_player_sel,
    output gcc_pkg::t_state o_state
);

    logic            mode_ok;
    logic            tick_left;
    gcc_pkg::t_time  mine;
    gcc_pkg::t_time  other;
    gcc_pkg::t_time  new_mine;
    gcc_pkg::t_time  new_other;
    gcc_pkg::t_time  new_grace;
    logic            tick_lost;
    gcc_pkg::t_time  excess;
    logic            press_left;
    gcc_pkg::t_time  tm;
    gcc_pkg::t_time  tm_inc;
    gcc_pkg::t_time  tm_cap1;
    gcc_pkg::t_time  tm_new;
    gcc_pkg::t_time  tourn_inc;
    gcc_pkg::t_moves mv_before;
    gcc_pkg::t_moves mv_new;
    logic            stepped;

    assign mode_ok = i_cfg.clock_mode <= gcc_pkg::MODE_STAGED;

    // Tick: charge elapsed time to the running side
    assign tick_left = i_state.active_side == gcc_pkg::SIDE_LEFT;
    assign mine      = tick_left ? i_state.left_remaining : i_state.right_remaining;
    assign other     = tick_left ? i_state.right_remaining : i_state.left_remaining;
    assign tick_lost = i_amount_ms > mine;
    assign excess    = i_amount_ms - i_state.grace_left;

    always_comb begin
        new_mine  = mine - i_amount_ms;
        new_other = other;
        new_grace = i_state.grace_left;
        if (tick_lost) begin
            new_mine = '0;
            if (i_cfg.clock_mode == gcc_pkg::MODE_TRANSFER) begin
                new_other = gcc_pkg::sat_add(other, mine);
            end
        end else begin
            case (i_cfg.clock_mode)
                gcc_pkg::MODE_GRACE: begin
                    if (i_amount_ms > i_state.grace_left) begin
                        new_mine  = mine - excess;
                        new_grace = '0;
                    end else begin
                        new_mine  = mine;
                        new_grace = i_state.grace_left - i_amount_ms;
                    end
                end
                gcc_pkg::MODE_TRANSFER: begin
                    new_other = gcc_pkg::sat_add(other, i_amount_ms);
                end
                gcc_pkg::MODE_CAPPED_ADD: begin
                    new_grace = (i_state.grace_left < i_amount_ms) ? '0
                              : i_state.grace_left - i_amount_ms;
                end
                default: ;
            endcase
        end
    end

    // Press: count the move and apply the mode's bonus
    assign press_left = i_player_sel == gcc_pkg::SIDE_LEFT;
    assign tm         = press_left ? i_state.left_remaining : i_state.right_remaining;
    assign mv_before  = press_left ? i_state.left_moves : i_state.right_moves;
    assign stepped    = mv_before != gcc_pkg::MOVES_MAX;
    assign mv_new     = stepped ? mv_before + gcc_pkg::t_moves'(1) : mv_before;

    always_comb begin
        if (mv_before < i_cfg.first_cap_moves) begin
            tourn_inc = i_cfg.bonus_ms;
        end else if (mv_before < i_cfg.second_cap_moves) begin
            tourn_inc = i_cfg.mid_increment_ms;
        end else begin
            tourn_inc = i_cfg.late_increment_ms;
        end
    end

    assign tm_inc  = gcc_pkg::sat_add(tm, tourn_inc);
    assign tm_cap1 = (stepped && mv_new == i_cfg.first_cap_moves)
                   ? gcc_pkg::sat_add(tm_inc, i_cfg.first_cap_bonus_ms) : tm_inc;

    always_comb begin
        tm_new = tm;
        case (i_cfg.clock_mode)
            gcc_pkg::MODE_PER_MOVE_ADD: tm_new = gcc_pkg::sat_add(tm, i_cfg.bonus_ms);
            gcc_pkg::MODE_CAPPED_ADD: begin
                if (i_cfg.bonus_ms > i_state.grace_left) begin
                    tm_new = gcc_pkg::sat_add(tm, i_cfg.bonus_ms - i_state.grace_left);
                end
            end
            gcc_pkg::MODE_STAGED: begin
                tm_new = (stepped && mv_new == i_cfg.second_cap_moves)
                       ? gcc_pkg::sat_add(tm_cap1, i_cfg.second_cap_bonus_ms) : tm_cap1;
            end
            default: ;
        endcase
    end

    // Select the command's effect
    always_comb begin
        o_state = i_state;
        case (i_cmd)
            gcc_pkg::CMD_TICK: begin
                if (mode_ok && (i_state.active_side inside
                                {gcc_pkg::SIDE_LEFT, gcc_pkg::SIDE_RIGHT})) begin
                    o_state.grace_left = new_grace;
                    if (tick_left) begin
                        o_state.left_remaining  = new_mine;
                        o_state.right_remaining = new_other;
                    end else begin
                        o_state.right_remaining = new_mine;
                        o_state.left_remaining  = new_other;
                    end
                    if (tick_lost) begin
                        o_state.outcome = tick_left ? gcc_pkg::SIDE_RIGHT : gcc_pkg::SIDE_LEFT;
                    end
                end
            end
            gcc_pkg::CMD_PRESS: begin
                if (mode_ok) begin
                    if (i_player_sel == gcc_pkg::SIDE_NONE) begin
                        o_state.active_side = gcc_pkg::SIDE_NONE;
                    end else if ((i_player_sel inside
                                  {gcc_pkg::SIDE_LEFT, gcc_pkg::SIDE_RIGHT}) && tm != '0) begin
                        if (i_cfg.clock_mode inside
                            {gcc_pkg::MODE_GRACE, gcc_pkg::MODE_CAPPED_ADD}) begin
                            o_state.grace_left = i_cfg.bonus_ms;
                        end
                        if (press_left) begin
                            o_state.left_remaining = tm_new;
                            o_state.left_moves     = mv_new;
                            o_state.active_side    = gcc_pkg::SIDE_RIGHT;
                        end else begin
                            o_state.right_remaining = tm_new;
                            o_state.right_moves     = mv_new;
                            o_state.active_side     = gcc_pkg::SIDE_LEFT;
                        end
                    end
                end
            end
            gcc_pkg::CMD_LOAD: begin
                if (i_player_sel == gcc_pkg::SIDE_LEFT) begin
                    o_state.left_remaining = i_amount_ms;
                    o_state.grace_left     = i_cfg.bonus_ms;
                end else if (i_player_sel == gcc_pkg::SIDE_RIGHT) begin
                    o_state.right_remaining = i_amount_ms;
                    o_state.grace_left      = i_cfg.bonus_ms;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/game_clock_time_control.sv]
// ----------------------------------------------------------------------------
// game_clock_time_control
// Two-player game clock with six time-control modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one command per item: an elapsed
//   tick, a player press or a load of one player's time. Each command yields
//   exactly one result item on the output channel (o_valid/i_ready) holding
//   both times, both move counts, the running side and the game result.
//   Configuration registers are written on the cfg channel, which is always
//   ready; write them only while no command is in flight.
//   A command is captured in the input register, then applied to the clock
//   state when the result slot is free; its result is valid once it is
//   committed. Throughput: one command per cycle while i_ready stays high,
//   set by combinational next-state logic that reads and writes the state
//   registers, which double as the result register. When the receiver
//   stalls, one more command waits in the input register and o_ready drops.
//   Reset (synchronous, active low) clears all state and configuration to
//   zero: times, counts, no running side, no result, sudden-death mode.
// ----------------------------------------------------------------------------
module game_clock_time_control (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [31:0]                 i_amount_ms,
    input  logic [1:0]                  i_player_sel,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_left_time_ms,
    output logic [31:0]                 o_right_time_ms,
    output logic [15:0]                 o_left_move_count,
    output logic [15:0]                 o_right_move_count,
    output logic [1:0]                  o_turn,
    output logic [1:0]                  o_winner,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gcc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);

    gcc_pkg::t_cfg   cfg;
    gcc_pkg::t_state r_state;
    gcc_pkg::t_state n_state;

    logic            r_in_valid;
    gcc_pkg::t_cmd   r_cmd;
    gcc_pkg::t_time  r_amount_ms;
    gcc_pkg::t_side  r_player_sel;
    logic            r_out_valid;
    logic            advance;

    gcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gcc_core u_core (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_cmd        (r_cmd),
        .i_amount_ms  (r_amount_ms),
        .i_player_sel (r_player_sel),
        .o_state      (n_state)
    );

    // Move the held item into the state when the result slot frees up
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Capture an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd        <= i_cmd;
            r_amount_ms  <= i_amount_ms;
            r_player_sel <= i_player_sel;
        end
    end

    // Commit the new state and flag the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_left_time_ms     = r_state.left_remaining;
    assign o_right_time_ms    = r_state.right_remaining;
    assign o_left_move_count  = r_state.left_moves;
    assign o_right_move_count = r_state.right_moves;
    assign o_turn             = r_state.active_side;
    assign o_winner           = r_state.outcome;

endmodule
